/* rtl/gdc_pkg.sv */
// Shared types, codes and calendar helpers for the Gregorian date converter.
package gdc_pkg;

    localparam logic CMD_TO_SERIAL = 1'b0;
    localparam logic CMD_TO_DATE   = 1'b1;

    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned SERIAL_W = 22;
    localparam int unsigned WDAY_W   = 3;
    localparam int unsigned DTY_W    = 23;  // days through any 14-bit year
    localparam int unsigned CUM_W    = 9;

    typedef struct packed {
        logic                cmd;
        logic [YEAR_W-1:0]   in_year;
        logic [MONTH_W-1:0]  in_month;
        logic [DAY_W-1:0]    in_day;
        logic [SERIAL_W-1:0] in_serial;
    } req_t;

    typedef struct packed {
        logic [SERIAL_W-1:0] out_serial;
        logic [YEAR_W-1:0]   out_year;
        logic [MONTH_W-1:0]  out_month;
        logic [DAY_W-1:0]    out_day;
        logic [WDAY_W-1:0]   weekday;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WAIT,
        ST_CHECK,
        ST_FIN
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic step;
        logic sum;
        logic delta;
        logic write;
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic rev;
        logic more;
    } stat_t;

    // days in the months before month idx+1
    function automatic logic [CUM_W-1:0] cum_days(input logic lp, input logic [3:0] idx);
        logic [CUM_W-1:0] c;
        logic [CUM_W-1:0] adj;
        adj = (lp && idx >= 4'd2) ? 9'd1 : 9'd0;
        case (idx)
            4'd0:    c = 9'd0;
            4'd1:    c = 9'd31;
            4'd2:    c = 9'd59;
            4'd3:    c = 9'd90;
            4'd4:    c = 9'd120;
            4'd5:    c = 9'd151;
            4'd6:    c = 9'd181;
            4'd7:    c = 9'd212;
            4'd8:    c = 9'd243;
            4'd9:    c = 9'd273;
            4'd10:   c = 9'd304;
            4'd11:   c = 9'd334;
            4'd12:   c = 9'd365;
            default: c = 9'd0;
        endcase
        return (idx <= 4'd12) ? c + adj : 9'd0;
    endfunction

    // modulo 7 by folding octal digits (8 = 1 mod 7)
    function automatic logic [WDAY_W-1:0] mod7(input logic [SERIAL_W-1:0] v);
        logic [5:0] a;
        logic [3:0] b;
        logic [3:0] c;
        a = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9])
          + 6'(v[14:12]) + 6'(v[17:15]) + 6'(v[20:18]) + 6'(v[21]);
        b = 4'(a[2:0]) + 4'(a[5:3]);
        c = 4'(b[2:0]) + 4'(b[3]);
        return (c == 4'd7) ? 3'd0 : c[2:0];
    endfunction

endpackage

/* rtl/gdc_datapath.sv */
// Datapath: operand registers, days-through-year unit, year search and month decode.
module gdc_datapath
    import gdc_pkg::*;
#(
    parameter int unsigned MAX_YEAR = 9999
)
(
    input  logic clk,
    input  logic rst_n,
    input  req_t req_data,
    input  ctl_t ctl,
    output stat_t stat,
    output rsp_t rsp_data
);

    localparam logic [15:0] MaxYear = 16'(MAX_YEAR);
    localparam logic [31:0] MaxDty  =
        32'(MAX_YEAR * 365 + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400);

    logic                rev_reg, rev_next;
    logic                ok_reg, ok_next;
    logic [YEAR_W-1:0]   y_reg, y_next;
    logic [SERIAL_W-1:0] ser_reg, ser_next;
    logic [MONTH_W-1:0]  mon_reg, mon_next;
    logic [DAY_W-1:0]    day_reg, day_next;
    logic [DTY_W-1:0]    dty_reg, dty_next;
    logic [7:0]          qp_reg, qp_next;
    logic [CUM_W-1:0]    delta_reg, delta_next;
    rsp_t                rsp_reg, rsp_next;

    logic [YEAR_W-1:0]   yp;
    logic [11:0]         q4;
    logic [26:0]         prod100;
    logic [24:0]         prod400;
    logic [26:0]         prodp;
    logic [33:0]         prod_y0;
    logic [YEAR_W-1:0]   y0;
    logic                lp;
    logic                ok_fwd;
    logic                ok_rev;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    dday;

    // days through year y_reg, and y_reg+1 / 100 for the leap test
    always_comb
    begin
        yp       = y_reg + 14'd1;
        q4       = y_reg[13:2];
        prod100  = 27'(y_reg) * 27'd5243;
        prod400  = 25'(q4) * 25'd5243;
        prodp    = 27'(yp) * 27'd5243;
        dty_next = 23'(y_reg) * 23'd365 + 23'(q4) - 23'(prod100[26:19]) + 23'(prod400[24:19]);
        qp_next  = prodp[26:19];
    end

    assign lp = (yp[1:0] == 2'b00) &&
                ((yp != 14'(qp_reg) * 14'd100) || (qp_reg[1:0] == 2'b00));

    // search start: at or above the answer for any serial
    assign prod_y0 = 34'(req_data.in_serial) * 34'd2874;
    assign y0      = prod_y0[33:20] + 14'd3;

    assign ok_fwd = (req_data.in_year != '0) && ({2'b00, req_data.in_year} <= MaxYear) &&
                    (req_data.in_month != '0) && (req_data.in_month <= 4'd12);
    assign ok_rev = (req_data.in_serial != '0) && ({10'd0, req_data.in_serial} <= MaxDty);

    always_comb
    begin
        logic [3:0] cnt;
        cnt = 4'd0;
        for (int k = 1; k < 12; k++)
        begin
            cnt = cnt + 4'(cum_days(lp, 4'(k)) < delta_reg);
        end
        month = 4'd1 + cnt;
        dday  = 5'(delta_reg - cum_days(lp, month - 4'd1));
    end

    always_comb
    begin
        rev_next   = rev_reg;
        ok_next    = ok_reg;
        y_next     = y_reg;
        ser_next   = ser_reg;
        mon_next   = mon_reg;
        day_next   = day_reg;
        delta_next = delta_reg;
        rsp_next   = rsp_reg;
        if (ctl.load)
        begin
            rev_next = req_data.cmd;
            mon_next = req_data.in_month;
            day_next = req_data.in_day;
            if (req_data.cmd == CMD_TO_DATE)
            begin
                ok_next  = ok_rev;
                y_next   = y0;
                ser_next = req_data.in_serial;
            end
            else
            begin
                ok_next  = ok_fwd;
                y_next   = req_data.in_year - 14'd1;
                ser_next = '0;
            end
        end
        if (ctl.step)
        begin
            y_next = y_reg - 14'd1;
        end
        if (ctl.sum)
        begin
            ser_next = ok_reg ? 22'(dty_reg + 23'(cum_days(lp, mon_reg - 4'd1)) + 23'(day_reg))
                              : '0;
        end
        if (ctl.delta)
        begin
            delta_next = 9'({1'b0, ser_reg} - dty_reg);
        end
        if (ctl.write)
        begin
            rsp_next.out_serial = ser_reg;
            rsp_next.weekday    = mod7(ser_reg);
            if (!ok_reg)
            begin
                rsp_next.out_year  = '0;
                rsp_next.out_month = '0;
                rsp_next.out_day   = '0;
            end
            else if (rev_reg == CMD_TO_DATE)
            begin
                rsp_next.out_year  = yp;
                rsp_next.out_month = month;
                rsp_next.out_day   = dday;
            end
            else
            begin
                rsp_next.out_year  = yp;
                rsp_next.out_month = mon_reg;
                rsp_next.out_day   = day_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rev_reg <= CMD_TO_SERIAL;
            ok_reg  <= 1'b0;
        end
        else
        begin
            rev_reg <= rev_next;
            ok_reg  <= ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg     <= y_next;
        ser_reg   <= ser_next;
        mon_reg   <= mon_next;
        day_reg   <= day_next;
        dty_reg   <= dty_next;
        qp_reg    <= qp_next;
        delta_reg <= delta_next;
        rsp_reg   <= rsp_next;
    end

    assign stat.rev  = (rev_reg == CMD_TO_DATE);
    assign stat.more = ok_reg && ({1'b0, ser_reg} <= dty_reg) && (y_reg != '0);
    assign rsp_data  = rsp_reg;

endmodule

/* rtl/gdc_controller.sv */
// Controller: sequencing state machine and result valid flag.
module gdc_controller
    import gdc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_ready,
    output logic  rsp_valid,
    input  logic  rsp_ready,
    input  stat_t stat,
    output ctl_t  ctl
);

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = (stat.rev && stat.more) ? ST_WAIT : ST_FIN;
            end
            ST_FIN:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl       = '0;
        req_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                ctl.load  = req_valid;
            end
            ST_CHECK:
            begin
                if (stat.rev)
                begin
                    ctl.step  = stat.more;
                    ctl.delta = !stat.more;
                end
                else
                begin
                    ctl.sum = 1'b1;
                end
            end
            ST_FIN:
            begin
                ctl.write = !rsp_valid_reg || rsp_ready;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

    always_comb
    begin
        if (ctl.write)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

/* rtl/gregorian_date_day_number_converter.sv */
// Sequence: a request is taken in idle and passes the wait and check states to the final
// state. Serial to date repeats wait and check once per year search step (at most 14 at
// the default year limit). A new input is taken only in idle, so a waiting result that
// has not been taken holds the final state and blocks the next input.
// Reset: rst_n asynchronous, active low; controller idle, no result pending.
module gregorian_date_day_number_converter
    import gdc_pkg::*;
#(
    parameter int unsigned MAX_YEAR = 9999
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req_data,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp_data
);

    // Command/status between sequencer and datapath.
    ctl_t  ctl;
    stat_t stat;

    // Sequencer: idle -> wait (days-through-year registers settle) -> check.
    // In reverse mode check steps the candidate year down until its span
    // holds the serial, then latches the offset into the year; forward mode
    // forms the serial there. The final state writes the output register
    // once the previous result has been taken.
    gdc_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    // Datapath: one registered days-through-year unit shared by both modes,
    // reciprocal multiplies for the /100 and /400 terms, parallel month
    // compares against the cumulative table and an octal-fold weekday.
    gdc_datapath #(
        .MAX_YEAR (MAX_YEAR)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_data (req_data),
        .ctl      (ctl),
        .stat     (stat),
        .rsp_data (rsp_data)
    );

endmodule
